// File: rtl/debounced_press_length_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the press-length classifier
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_PRESS_LENGTH_CLASSIFIER_CORE_DEFINES_SVH
`define DEBOUNCED_PRESS_LENGTH_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication
`define DPLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DPLC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dplc_pkg.sv
// ----------------------------------------------------------------------------
// dplc_pkg
// Types and constants of the debounced press-length classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dplc_pkg;

  // Configuration register width and default counter width
  localparam int unsigned CfgW         = 16;
  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned CfgAddrW     = 3;

  // Stream data widths (padded to whole bytes)
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  // Register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_MEDIUM      = 3'd1,
    REG_LONG        = 3'd2,
    REG_REPORT_HELD = 3'd3
  } reg_idx_e;

  // Reset values of the registers
  localparam logic [CfgW-1:0] DebounceRst = 16'd50;
  localparam logic [CfgW-1:0] MediumRst   = 16'd2000;
  localparam logic [CfgW-1:0] LongRst     = 16'd5000;

  // Press classes, used for both event and hold level
  typedef enum logic [1:0] {
    PRESS_NONE   = 2'd0,
    PRESS_SHORT  = 2'd1,
    PRESS_MEDIUM = 2'd2,
    PRESS_LONG   = 2'd3
  } press_e;

  // Pin levels (active low button)
  localparam logic LvlPressed  = 1'b0;
  localparam logic LvlReleased = 1'b1;

  // One result transaction
  typedef struct packed {
    press_e held_level;
    press_e press_event;
  } result_t;

endpackage

// File: rtl/debounced_press_length_classifier_core.sv
// ----------------------------------------------------------------------------
// debounced_press_length_classifier_core
// Button debouncer with short / medium / long press classification.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one transaction per millisecond tick: tdata[0] is the raw
//   active-low pin level. m_axis returns exactly one transaction per tick:
//   press_event (none, short, medium, long) and held_level (current class).
//   cfg_we_i / cfg_addr_i / cfg_wdata_i write the debounce time, the medium
//   and long thresholds and the report-while-held mode; write only when idle.
// Output: a tick's result is registered in the output register, or in the skid on a stall.
// Throughput: one tick per cycle while the skid is empty; the state update is a
//   saturating add and a few 16-bit compares between the state and result registers.
// Stall: an output register plus a one-entry skid register; s_axis_tready
//   drops only when both hold results, so one extra tick is taken while the
//   receiver stalls.
// Reset: rst_ni (async, active low) returns all registers to their defaults,
//   the pin state to released, both ages to zero and empties the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "debounced_press_length_classifier_core_defines.svh"

module debounced_press_length_classifier_core #(
  parameter int unsigned COUNT_WIDTH = dplc_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [dplc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [dplc_pkg::CfgW-1:0]     cfg_wdata_i,
  // tick input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dplc_pkg::InDataW-1:0]  s_axis_tdata,   // [0] raw_level
  // result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dplc_pkg::OutDataW-1:0] m_axis_tdata    // [1:0] press_event, [3:2] held_level
);

  import dplc_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > CfgW) ? COUNT_WIDTH : CfgW;
  localparam logic [COUNT_WIDTH-1:0] AgeMax = {COUNT_WIDTH{1'b1}};

  // Configuration registers
  logic [CfgW-1:0] debounce_q, medium_q, long_q;
  logic            rwh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      medium_q   <= MediumRst;
      long_q     <= LongRst;
      rwh_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DEBOUNCE:    debounce_q <= cfg_wdata_i;
        REG_MEDIUM:      medium_q   <= cfg_wdata_i;
        REG_LONG:        long_q     <= cfg_wdata_i;
        REG_REPORT_HELD: rwh_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Tracking state
  logic                   prev_raw_q, prev_raw_d;
  logic                   stable_q, stable_d;
  logic [COUNT_WIDTH-1:0] edge_age_q, edge_age_d;
  logic [COUNT_WIDTH-1:0] press_age_q, press_age_d;
  press_e                 prev_held_q, prev_held_d;

  logic    s_accept;
  logic    raw;
  result_t res;

  logic [CmpW-1:0] edge_x, press_x, deb_x, med_x, long_x;
  logic [COUNT_WIDTH-1:0] edge_inc, press_inc;
  logic            is_stable;

  assign raw = s_axis_tdata[0];

  // Per-tick classification
  always_comb begin
    edge_inc  = (edge_age_q == AgeMax) ? AgeMax : edge_age_q + COUNT_WIDTH'(1);
    press_inc = (press_age_q == AgeMax) ? AgeMax : press_age_q + COUNT_WIDTH'(1);
    edge_age_d  = (raw != prev_raw_q) ? '0 : edge_inc;
    press_age_d = press_inc;

    edge_x  = CmpW'(edge_age_d);
    press_x = CmpW'(press_inc);
    deb_x   = CmpW'(debounce_q);
    med_x   = CmpW'(medium_q);
    long_x  = CmpW'(long_q);

    is_stable       = edge_x > deb_x;
    prev_raw_d      = prev_raw_q;
    stable_d        = stable_q;
    prev_held_d     = prev_held_q;
    res.press_event = PRESS_NONE;
    res.held_level  = PRESS_NONE;

    if (is_stable) begin
      // release report or start of a stable press
      if (raw == LvlPressed && stable_q == LvlReleased) begin
        press_age_d = '0;
        stable_d    = LvlPressed;
      end else if (raw == LvlReleased && stable_q == LvlPressed) begin
        stable_d = LvlReleased;
        if (press_x < med_x) begin
          res.press_event = PRESS_SHORT;
        end else if (press_x < long_x) begin
          if (!rwh_q) res.press_event = PRESS_MEDIUM;
        end else if (!rwh_q) begin
          res.press_event = PRESS_LONG;
        end
      end
      // hold class; in hold mode a threshold crossing reports once
      if (raw == LvlPressed) begin
        res.held_level = PRESS_SHORT;
        if (edge_x >= med_x) begin
          res.held_level = PRESS_MEDIUM;
          if (rwh_q && prev_held_q == PRESS_SHORT) res.press_event = PRESS_MEDIUM;
        end
        if (edge_x >= long_x) begin
          res.held_level = PRESS_LONG;
          if (rwh_q && prev_held_q == PRESS_MEDIUM) res.press_event = PRESS_LONG;
        end
      end
      prev_held_d = res.held_level;
    end else begin
      prev_raw_d = raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q  <= LvlReleased;
      stable_q    <= LvlReleased;
      edge_age_q  <= '0;
      press_age_q <= '0;
      prev_held_q <= PRESS_NONE;
    end else if (s_accept) begin
      prev_raw_q  <= prev_raw_d;
      stable_q    <= stable_d;
      edge_age_q  <= edge_age_d;
      press_age_q <= press_age_d;
      prev_held_q <= prev_held_d;
    end
  end

  // Output register with one-entry skid
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    m_pop;

  assign s_axis_tready = !skid_valid_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_pop         = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (s_accept) begin
      if (out_valid_q && !m_pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (m_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_pop) out_q <= skid_q;
    end else if (s_accept) begin
      if (out_valid_q && !m_pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

  // Assertions
  `DPLC_ASSERT_IMP(a_skid_needs_out, skid_valid_q, out_valid_q,
                   "skid full with output empty")
  `DPLC_ASSERT_IMP(a_skid_blocks_in, skid_valid_q, !s_axis_tready,
                   "input open with skid full")
  `DPLC_ASSERT_NXT(a_stall_fills_skid, s_accept && out_valid_q && !m_axis_tready,
                   skid_valid_q, "stalled result not parked in skid")
  `DPLC_ASSERT_NXT(a_edge_clears_age, s_accept && (raw != prev_raw_q),
                   edge_age_q == '0, "raw edge did not clear edge age")

endmodule
